FILE: sv/euler_angles_to_rotation_matrix_defines.svh
// Assertion macros for the rotation matrix block
`ifndef EULER_ANGLES_TO_ROTATION_MATRIX_DEFINES_SVH
`define EULER_ANGLES_TO_ROTATION_MATRIX_DEFINES_SVH
// assert that a implies b on the next clock
`define EAR_ASSERT_NEXT(label, clk, rst, a, b) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
      else $error("assertion failed");
// assert that a implies b in the same clock
`define EAR_ASSERT_NOW(label, clk, rst, a, b) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
      else $error("assertion failed");
`endif

FILE: sv/ear_pkg.sv
// Shared constants, types and functions of the rotation matrix block
`timescale 1ns / 1ps
package ear_pkg;
   localparam int CordicStages = 24;
   localparam int StageIdxW = $clog2(CordicStages + 1);
   localparam logic signed [33:0] OneQ30 = 34'sd1073741824;
   localparam logic signed [31:0] OneWord = 32'sd1073741824;
   localparam logic signed [33:0] PiQ29 = 34'sd1686629713;
   localparam logic signed [33:0] HalfPiQ29 = 34'sd843314857;
   localparam logic signed [33:0] GainQ30 = 34'sd652032874;
   localparam int MulLatency = 3;
   localparam int Latency = CordicStages + 2 + MulLatency;

   typedef logic signed [33:0] wide_type;
   typedef logic signed [31:0] word_type;

   typedef struct packed {
      wide_type x;
      wide_type y;
      wide_type z;
      logic     neg;
   } cordic_type;

   function automatic wide_type atan_q29(input int i);
      logic signed [63:0] sum;
      logic [63:0] term;
      logic [63:0] num;
      logic [63:0] den;
      logic [63:0] rem;
      int k;
      sum = 64'sd0;
      if (i == 0) begin
         return 34'sd421657428;
      end
      for (k = 0; k < 32; k++) begin
         if (i * (2 * k + 1) <= 62) begin
            num = 64'd1 << (62 - i * (2 * k + 1));
            den = 64'(2 * k + 1);
            rem = 64'd0;
            term = 64'd0;
            for (int b = 63; b >= 0; b--) begin
               rem = {rem[62:0], num[b]};
               if (rem >= den) begin
                  rem = rem - den;
                  term[b] = 1'b1;
               end
            end
            if (k[0]) sum = sum - $signed(term);
            else sum = sum + $signed(term);
         end
      end
      sum = (sum + (64'sd1 <<< 32)) >>> 33;
      return sum[33:0];
   endfunction

   function automatic wide_type sat1(input wide_type v);
      if (v > OneQ30) return OneQ30;
      if (v < -OneQ30) return -OneQ30;
      return v;
   endfunction

   function automatic wide_type rnd(input wide_type a, input wide_type b);
      logic signed [67:0] t;
      t = (68'(a) * 68'(b) + 68'sd536870912) >>> 30;
      return t[33:0];
   endfunction
endpackage

FILE: sv/ear_cordic.sv
// Pipelined rotation-mode CORDIC lane giving sine and cosine of one angle
`timescale 1ns / 1ps
module ear_cordic (
   input  logic                  clock,
   input  ear_pkg::word_type     angle,
   output ear_pkg::wide_type     sin_out,
   output ear_pkg::wide_type     cos_out
);
   ear_pkg::cordic_type st_ff [ear_pkg::CordicStages+1];
   ear_pkg::cordic_type st_in [ear_pkg::CordicStages+1];
   ear_pkg::wide_type sin_ff, cos_ff, sin_in, cos_in;

   always_comb begin
      ear_pkg::wide_type z;
      z = ear_pkg::wide_type'(angle);
      st_in[0].x = ear_pkg::GainQ30;
      st_in[0].y = '0;
      st_in[0].neg = 1'b0;
      st_in[0].z = z;
      if (z > ear_pkg::HalfPiQ29) begin
         st_in[0].z = z - ear_pkg::PiQ29;
         st_in[0].neg = 1'b1;
      end else if (z < -ear_pkg::HalfPiQ29) begin
         st_in[0].z = z + ear_pkg::PiQ29;
         st_in[0].neg = 1'b1;
      end
   end

   for (genvar i = 0; i < ear_pkg::CordicStages; i++) begin : g_stage
      localparam ear_pkg::wide_type Atan = ear_pkg::atan_q29(i);
      always_comb begin
         st_in[i+1].neg = st_ff[i].neg;
         if (!st_ff[i].z[33]) begin
            st_in[i+1].x = st_ff[i].x - (st_ff[i].y >>> i);
            st_in[i+1].y = st_ff[i].y + (st_ff[i].x >>> i);
            st_in[i+1].z = st_ff[i].z - Atan;
         end else begin
            st_in[i+1].x = st_ff[i].x + (st_ff[i].y >>> i);
            st_in[i+1].y = st_ff[i].y - (st_ff[i].x >>> i);
            st_in[i+1].z = st_ff[i].z + Atan;
         end
      end
   end

   always_comb begin
      ear_pkg::cordic_type f;
      f = st_ff[ear_pkg::CordicStages];
      cos_in = ear_pkg::sat1(f.x);
      sin_in = ear_pkg::sat1(f.y);
      if (f.neg) begin
         cos_in = -cos_in;
         sin_in = -sin_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int j = 0; j <= ear_pkg::CordicStages; j++) st_ff[j] <= st_in[j];
      sin_ff <= sin_in;
      cos_ff <= cos_in;
   end

   assign sin_out = sin_ff;
   assign cos_out = cos_ff;
endmodule

FILE: sv/ear_merge.sv
// Product and sum stages that combine lane outputs into the rotation matrix
`timescale 1ns / 1ps
module ear_merge (
   input  logic              clock,
   input  ear_pkg::wide_type so, co, sp, cp, sk, ck,
   output ear_pkg::word_type m [9]
);
   ear_pkg::wide_type p1_ff [6], p1_in [6];
   ear_pkg::wide_type f_ff [5], f_in [5];
   ear_pkg::wide_type q_ff [8], q_in [8];
   ear_pkg::wide_type d_ff [5], d_in [5];
   ear_pkg::word_type m_ff [9], m_in [9];

   always_comb begin
      p1_in[0] = ear_pkg::rnd(so, sp);
      p1_in[1] = ear_pkg::rnd(co, sp);
      p1_in[2] = ear_pkg::rnd(cp, ck);
      p1_in[3] = ear_pkg::rnd(cp, sk);
      p1_in[4] = ear_pkg::rnd(so, cp);
      p1_in[5] = ear_pkg::rnd(co, cp);
      f_in = '{so, co, sp, sk, ck};
   end

   always_comb begin
      q_in[0] = ear_pkg::rnd(f_ff[1], f_ff[3]);
      q_in[1] = ear_pkg::rnd(p1_ff[0], f_ff[4]);
      q_in[2] = ear_pkg::rnd(f_ff[1], f_ff[4]);
      q_in[3] = ear_pkg::rnd(p1_ff[0], f_ff[3]);
      q_in[4] = ear_pkg::rnd(f_ff[0], f_ff[3]);
      q_in[5] = ear_pkg::rnd(p1_ff[1], f_ff[4]);
      q_in[6] = ear_pkg::rnd(f_ff[0], f_ff[4]);
      q_in[7] = ear_pkg::rnd(p1_ff[1], f_ff[3]);
      d_in = '{p1_ff[2], -p1_ff[3], f_ff[2], -p1_ff[4], p1_ff[5]};
   end

   always_comb begin
      ear_pkg::wide_type r [9];
      r[0] = d_ff[0];
      r[1] = d_ff[1];
      r[2] = d_ff[2];
      r[3] = q_ff[0] + q_ff[1];
      r[4] = q_ff[2] - q_ff[3];
      r[5] = d_ff[3];
      r[6] = q_ff[4] - q_ff[5];
      r[7] = q_ff[6] + q_ff[7];
      r[8] = d_ff[4];
      for (int j = 0; j < 9; j++) begin
         r[j] = ear_pkg::sat1(r[j]);
         m_in[j] = r[j][31:0];
      end
   end

   always_ff @(posedge clock) begin
      p1_ff <= p1_in;
      f_ff <= f_in;
      q_ff <= q_in;
      d_ff <= d_in;
      m_ff <= m_in;
   end

   assign m = m_ff;
endmodule

FILE: sv/euler_angles_to_rotation_matrix.sv
// Top level: omega-phi-kappa angles to 3x3 rotation matrix
// Path from start to rsp_valid: the CORDIC stage registers, the lane output register, then the merge registers.
// Throughput: one request per cycle; busy stays low, set by the fully pipelined lanes.
// Three CORDIC lanes run in parallel, then a three-stage product and sum pipeline.
// Reset clears the valid pipeline only; results are never held off.
`timescale 1ns / 1ps
module euler_angles_to_rotation_matrix (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  ear_pkg::word_type req_omega,
   input  ear_pkg::word_type req_phi,
   input  ear_pkg::word_type req_kappa,
   output logic              rsp_valid,
   output ear_pkg::word_type rsp_r00, rsp_r01, rsp_r02,
   output ear_pkg::word_type rsp_r10, rsp_r11, rsp_r12,
   output ear_pkg::word_type rsp_r20, rsp_r21, rsp_r22
);
   logic [ear_pkg::Latency-1:0] vld_ff, vld_in;
   ear_pkg::wide_type so, co, sp, cp, sk, ck;
   ear_pkg::word_type m [9];

   ear_cordic u_omega (.clock(clock), .angle(req_omega), .sin_out(so), .cos_out(co));
   ear_cordic u_phi   (.clock(clock), .angle(req_phi),   .sin_out(sp), .cos_out(cp));
   ear_cordic u_kappa (.clock(clock), .angle(req_kappa), .sin_out(sk), .cos_out(ck));

   ear_merge u_merge (
      .clock(clock), .so(so), .co(co), .sp(sp), .cp(cp), .sk(sk), .ck(ck), .m(m)
   );

   assign busy = 1'b0;
   assign vld_in = {vld_ff[ear_pkg::Latency-2:0], start & ~busy};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   assign rsp_valid = vld_ff[ear_pkg::Latency-1];
   assign rsp_r00 = m[0];
   assign rsp_r01 = m[1];
   assign rsp_r02 = m[2];
   assign rsp_r10 = m[3];
   assign rsp_r11 = m[4];
   assign rsp_r12 = m[5];
   assign rsp_r20 = m[6];
   assign rsp_r21 = m[7];
   assign rsp_r22 = m[8];
endmodule

FILE: sv/ear_checker.sv
// Port-level checker for the rotation matrix block, bound to the top level
`timescale 1ns / 1ps
`include "euler_angles_to_rotation_matrix_defines.svh"
module ear_checker (
   input logic              clock,
   input logic              reset,
   input logic              start,
   input logic              busy,
   input logic              rsp_valid,
   input ear_pkg::word_type rsp_r02,
   input ear_pkg::word_type rsp_r00,
   input ear_pkg::word_type rsp_r22
);
   `EAR_ASSERT_NOW(a_never_busy, clock, reset, start, !busy)
   `EAR_ASSERT_NOW(a_r02_range, clock, reset, rsp_valid, rsp_r02 <= ear_pkg::OneWord && rsp_r02 >= -ear_pkg::OneWord)
   `EAR_ASSERT_NOW(a_r00_range, clock, reset, rsp_valid, rsp_r00 <= ear_pkg::OneWord && rsp_r00 >= -ear_pkg::OneWord)
   `EAR_ASSERT_NOW(a_r22_range, clock, reset, rsp_valid, rsp_r22 <= ear_pkg::OneWord && rsp_r22 >= -ear_pkg::OneWord)
   `EAR_ASSERT_NEXT(a_idle_after_reset, clock, 1'b0, reset, !rsp_valid)
endmodule

bind euler_angles_to_rotation_matrix ear_checker u_ear_checker (
   .clock(clock), .reset(reset), .start(start), .busy(busy), .rsp_valid(rsp_valid),
   .rsp_r02(rsp_r02), .rsp_r00(rsp_r00), .rsp_r22(rsp_r22)
);

FILE: test/tb_euler_angles_to_rotation_matrix.sv
// Testbench for the omega-phi-kappa rotation matrix block: directed and random angles
`timescale 1ns / 1ps
module tb_euler_angles_to_rotation_matrix;
   typedef logic [8:0][31:0] matrix_type;

   logic              clock;
   logic              reset;
   logic              start;
   logic              busy;
   ear_pkg::word_type req_omega, req_phi, req_kappa;
   logic              rsp_valid;
   ear_pkg::word_type rsp_r00, rsp_r01, rsp_r02;
   ear_pkg::word_type rsp_r10, rsp_r11, rsp_r12;
   ear_pkg::word_type rsp_r20, rsp_r21, rsp_r22;

   localparam longint OneFix = 64'sd1073741824;
   localparam longint HalfFix = 64'sd536870912;
   localparam longint PiFix = 64'sd1686629713;
   localparam longint HalfPiFix = 64'sd843314857;
   localparam longint GainFix = 64'sd652032874;
   localparam int NumItems = 1450;

   matrix_type pending_matrices[$];
   longint     arctan_tab[0:63];
   bit         failed = 0;

   euler_angles_to_rotation_matrix DUT (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_omega(req_omega), .req_phi(req_phi), .req_kappa(req_kappa),
      .rsp_valid(rsp_valid),
      .rsp_r00(rsp_r00), .rsp_r01(rsp_r01), .rsp_r02(rsp_r02),
      .rsp_r10(rsp_r10), .rsp_r11(rsp_r11), .rsp_r12(rsp_r12),
      .rsp_r20(rsp_r20), .rsp_r21(rsp_r21), .rsp_r22(rsp_r22)
   );

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   function automatic longint clamp_unit(input longint v);
      if (v > OneFix) return OneFix;
      if (v < -OneFix) return -OneFix;
      return v;
   endfunction

   function automatic longint fix_mul(input longint a, input longint b);
      return (a * b + HalfFix) >>> 30;
   endfunction

   function automatic void angle_sincos(input ear_pkg::word_type ang, output longint s,
                                        output longint c);
      longint z, x, y, dx, dy;
      bit     flip;
      int     n;
      z = longint'(ang);
      x = GainFix;
      y = 0;
      flip = 0;
      if (z > HalfPiFix) begin
         z = z - PiFix;
         flip = 1;
      end else if (z < -HalfPiFix) begin
         z = z + PiFix;
         flip = 1;
      end
      n = (ear_pkg::CordicStages > 62) ? 62 : ear_pkg::CordicStages;
      for (int i = 0; i < n; i++) begin
         dx = y >>> i;
         dy = x >>> i;
         if (z >= 0) begin
            x = x - dx;
            y = y + dy;
            z = z - arctan_tab[i];
         end else begin
            x = x + dx;
            y = y - dy;
            z = z + arctan_tab[i];
         end
      end
      x = clamp_unit(x);
      y = clamp_unit(y);
      if (flip) begin
         x = -x;
         y = -y;
      end
      c = x;
      s = y;
   endfunction

   function automatic matrix_type rotation_of(input ear_pkg::word_type om,
                                              input ear_pkg::word_type ph,
                                              input ear_pkg::word_type ka);
      longint     so, co, sp, cp, sk, ck, sosp, cosp;
      longint     m[9];
      matrix_type r;
      angle_sincos(om, so, co);
      angle_sincos(ph, sp, cp);
      angle_sincos(ka, sk, ck);
      sosp = fix_mul(so, sp);
      cosp = fix_mul(co, sp);
      m[0] = fix_mul(cp, ck);
      m[1] = -fix_mul(cp, sk);
      m[2] = sp;
      m[3] = fix_mul(co, sk) + fix_mul(sosp, ck);
      m[4] = fix_mul(co, ck) - fix_mul(sosp, sk);
      m[5] = -fix_mul(so, cp);
      m[6] = fix_mul(so, sk) - fix_mul(cosp, ck);
      m[7] = fix_mul(so, ck) + fix_mul(cosp, sk);
      m[8] = fix_mul(co, cp);
      for (int j = 0; j < 9; j++) r[j] = 32'(clamp_unit(m[j]));
      return r;
   endfunction

   initial begin
      longint sum, term;
      int     e;
      arctan_tab[0] = 64'sd421657428;
      for (int i = 1; i < 64; i++) begin
         sum = 0;
         for (int k = 0; i * (2 * k + 1) <= 62; k++) begin
            e = 62 - i * (2 * k + 1);
            term = longint'((64'd1 << e) / (2 * k + 1));
            if (k % 2 == 1) sum = sum - term;
            else sum = sum + term;
         end
         arctan_tab[i] = (sum + (64'sd1 <<< 32)) >>> 33;
      end
   end

   always @(posedge clock) begin
      matrix_type got, want;
      if (!reset) begin
         if (rsp_valid) begin
            got = {rsp_r22, rsp_r21, rsp_r20, rsp_r12, rsp_r11, rsp_r10,
                   rsp_r02, rsp_r01, rsp_r00};
            if (pending_matrices.size() == 0) begin
               $display("%0t: unexpected result, actual %p", $time, got);
               failed = 1;
            end else begin
               want = pending_matrices.pop_front();
               for (int j = 0; j < 9; j++) begin
                  if (got[j] !== want[j]) begin
                     $display("%0t: element r%0d%0d expected %0d actual %0d", $time,
                              j / 3, j % 3, $signed(want[j]), $signed(got[j]));
                     failed = 1;
                  end
               end
            end
         end
         if (start && !busy)
            pending_matrices.push_back(rotation_of(req_omega, req_phi, req_kappa));
      end
   end

   task automatic send_request(input ear_pkg::word_type om, input ear_pkg::word_type ph,
                               input ear_pkg::word_type ka, input int gap);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start <= 1'b1;
      req_omega <= om;
      req_phi <= ph;
      req_kappa <= ka;
      @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 70) return 0;
      if (r < 95) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   function automatic ear_pkg::word_type pick_angle();
      int r;
      r = $urandom_range(0, 9);
      if (r < 6) return ear_pkg::word_type'($urandom_range(0, 32'(2 * PiFix)) - PiFix);
      if (r < 8) return $urandom();
      return ear_pkg::word_type'((($urandom_range(0, 1)) ? HalfPiFix : -HalfPiFix)
                                 + $urandom_range(0, 8) - 4);
   endfunction

   typedef struct {
      ear_pkg::word_type om;
      ear_pkg::word_type ph;
      ear_pkg::word_type ka;
   } angles_type;

   angles_type directed_rows [18] = '{
      '{32'sd0, 32'sd0, 32'sd0},
      '{32'h7FFFFFFF, 32'sd0, 32'sd0},
      '{32'sd0, 32'h7FFFFFFF, 32'sd0},
      '{32'sd0, 32'sd0, 32'h7FFFFFFF},
      '{32'h80000000, 32'h80000000, 32'h80000000},
      '{32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF},
      '{32'sd843314857, 32'sd843314857, 32'sd843314857},
      '{-32'sd843314857, -32'sd843314857, -32'sd843314857},
      '{32'sd843314858, -32'sd843314858, 32'sd843314858},
      '{32'sd1686629713, -32'sd1686629713, 32'sd0},
      '{32'sd421657428, 32'sd421657428, 32'sd421657428},
      '{-32'sd421657428, 32'sd843314857, -32'sd1},
      '{32'sd1, -32'sd1, 32'sd1},
      '{32'hFFFFFFFF, 32'h55555555, 32'hAAAAAAAA},
      '{32'hAAAAAAAA, 32'hFFFFFFFF, 32'h55555555},
      '{32'h55555555, 32'hAAAAAAAA, 32'hFFFFFFFF},
      '{32'sd900000000, -32'sd1200000000, 32'sd1600000000},
      '{-32'sd1686629712, 32'sd1686629714, -32'sd843314858}
   };

   initial begin
      reset = 1'b1;
      start = 1'b0;
      req_omega = '0;
      req_phi = '0;
      req_kappa = '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      foreach (directed_rows[i])
         send_request(directed_rows[i].om, directed_rows[i].ph, directed_rows[i].ka,
                      (i % 4 == 3) ? 2 : 0);
      for (int n = 0; n < NumItems; n++) begin
         if (n == NumItems / 2) begin
            start <= 1'b0;
            @(posedge clock);
            while (pending_matrices.size() != 0) @(posedge clock);
         end
         send_request(pick_angle(), pick_angle(), pick_angle(),
                      (n % 300 < 60) ? 0 : pick_gap());
      end
      start <= 1'b0;
      @(posedge clock);
      while (pending_matrices.size() != 0) @(posedge clock);
      repeat (ear_pkg::Latency + 10) @(posedge clock);
      if (!failed)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

   initial begin
      #5ms;
      $display("Test completed with failures");
      $finish;
   end
endmodule
